// ===== hw/rtl/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg - shared definitions for the canonical line editor
// Sizes, character codes, result kinds, register indexes and reset values,
// plus the control state type and the ring pointer helpers of the editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int BUF_DEPTH = 2048;
    localparam int MAX_READ  = 64;

    localparam int PTR_W  = $clog2(BUF_DEPTH);
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int CHAR_W = 8;
    localparam int LIM_W  = 7;
    localparam int ECNT_W = 12;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 3;
    localparam int SAT_W  = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

    localparam logic [ECNT_W-1:0] ECNT_MAX = {ECNT_W{1'b1}};

    // character codes
    localparam logic [CHAR_W-1:0] CH_DEL = 8'd127;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;

    // request type
    localparam logic REQ_READ = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO_CHAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO_ERASE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INTR       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_EMPTY = 3'd4;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_CANON  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_ECHO   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_SIGNAL = 3'd2;
    localparam logic [CFG_W-1:0] CFG_INTR   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_ERASE  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_KILL   = 3'd5;

    // configuration reset values
    localparam logic [CHAR_W-1:0] RST_INTR  = 8'd3;
    localparam logic [CHAR_W-1:0] RST_ERASE = 8'd8;
    localparam logic [CHAR_W-1:0] RST_KILL  = 8'd21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_KILL_ISSUE,
        ST_KILL_CHECK,
        ST_READ_ISSUE,
        ST_READ_DATA
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + 1'b1;
        return (sum >= (PTR_W+1)'(BUF_DEPTH)) ? '0 : sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(BUF_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// ===== hw/rtl/canonical_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_line_editor - keyboard line discipline over a character ring
// Key items are edited into a ring buffer held in one synchronous RAM;
// read items drain it.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_type, key_char, read_limit) is taken at a clock edge with
//   start high and busy low. Results appear on kind, out_char, erase_count
//   and last for one cycle each, marked by valid; last flags the final
//   result of the item. Items that cause no result just drop busy.
//   Steps, from the accepting edge to busy low:
//     key (store, erase, interrupt): the KEY state alone
//     kill: KEY, then KILL_ISSUE and KILL_CHECK for each erased character,
//       ending in KILL_ISSUE on an empty buffer or in KILL_CHECK at a newline
//     read: READ_ISSUE and READ_DATA per byte delivered (empty: READ_ISSUE)
//   Every buffer read goes through the registered read port of the RAM,
//   so each walked character takes an address step and a data step.
//   A result shows the cycle after the step that produces it.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   idle; indexes past the last register are ignored.
//   Reset clears the pointers and fill count (empty buffer) and loads the
//   register defaults; the RAM itself is not cleared. Results cannot be
//   held off by the receiver.
// ----------------------------------------------------------------------------
module canonical_line_editor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [cle_pkg::CHAR_W-1:0]     key_char,
    input  logic [cle_pkg::LIM_W-1:0]      read_limit,
    output logic                           valid,
    output logic [cle_pkg::KIND_W-1:0]     kind,
    output logic [cle_pkg::CHAR_W-1:0]     out_char,
    output logic [cle_pkg::ECNT_W-1:0]     erase_count,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [cle_pkg::CFG_W-1:0]      cfg_index,
    input  logic [cle_pkg::CHAR_W-1:0]     cfg_data
);

    cle_pkg::state_t state_reg, state_next;

    // latched item
    logic [cle_pkg::CHAR_W-1:0]  key_char_reg;
    logic [cle_pkg::LIM_W-1:0]   lim_reg;

    // buffer state
    logic [cle_pkg::PTR_W-1:0]   wp_reg, wp_next;
    logic [cle_pkg::PTR_W-1:0]   rp_reg, rp_next;
    logic [cle_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [cle_pkg::CNT_W-1:0]   kcnt_reg, kcnt_next;
    logic [cle_pkg::LIM_W-1:0]   rcnt_reg, rcnt_next;

    // configuration
    logic                        canon_reg, echo_reg, sig_reg;
    logic [cle_pkg::CHAR_W-1:0]  intr_reg, erase_reg, kill_reg;

    // result registers
    logic                        valid_reg, valid_next;
    logic [cle_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [cle_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic [cle_pkg::ECNT_W-1:0]  ecnt_reg, ecnt_next;
    logic                        last_reg, last_next;

    // character RAM
    logic [cle_pkg::CHAR_W-1:0]  mem [cle_pkg::BUF_DEPTH];
    logic                        mem_we, mem_re;
    logic [cle_pkg::PTR_W-1:0]   mem_waddr, mem_raddr;
    logic [cle_pkg::CHAR_W-1:0]  mem_wdata, rdata_reg;

    logic                        accept;
    logic                        is_intr, is_erase, is_kill, buf_full, buf_empty;
    logic [cle_pkg::CHAR_W-1:0]  store_char;
    logic                        rd_last;
    logic [cle_pkg::LIM_W-1:0]   rcnt_inc;
    logic [cle_pkg::SAT_W-1:0]   kcnt_wide;
    logic [cle_pkg::ECNT_W-1:0]  kcnt_sat;

    assign accept = start && (state_reg == cle_pkg::ST_IDLE);
    assign busy   = (state_reg != cle_pkg::ST_IDLE);

    assign is_intr   = sig_reg && (key_char_reg == intr_reg);
    assign is_erase  = canon_reg &&
                       ((key_char_reg == erase_reg) || (key_char_reg == cle_pkg::CH_DEL));
    assign is_kill   = canon_reg && (key_char_reg == kill_reg);
    assign buf_full  = (fill_reg == cle_pkg::CNT_W'(cle_pkg::BUF_DEPTH));
    assign buf_empty = (fill_reg == '0);
    assign store_char = (key_char_reg == cle_pkg::CH_CR) ? cle_pkg::CH_LF : key_char_reg;

    assign rcnt_inc = rcnt_reg + 1'b1;
    assign rd_last  = (rcnt_inc == lim_reg) ||
                      (fill_reg == cle_pkg::CNT_W'(1)) ||
                      (canon_reg && (rdata_reg == cle_pkg::CH_LF));

    assign kcnt_wide = cle_pkg::SAT_W'(kcnt_reg);
    assign kcnt_sat  = (kcnt_wide > cle_pkg::SAT_W'(cle_pkg::ECNT_MAX)) ?
                       cle_pkg::ECNT_MAX : kcnt_wide[cle_pkg::ECNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == cle_pkg::REQ_READ) ?
                                 cle_pkg::ST_READ_ISSUE : cle_pkg::ST_KEY;
                end
            end
            cle_pkg::ST_KEY:
            begin
                if (!is_intr && !is_erase && is_kill)
                    state_next = cle_pkg::ST_KILL_ISSUE;
                else
                    state_next = cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_KILL_ISSUE:
            begin
                state_next = buf_empty ? cle_pkg::ST_IDLE : cle_pkg::ST_KILL_CHECK;
            end
            cle_pkg::ST_KILL_CHECK:
            begin
                state_next = (rdata_reg == cle_pkg::CH_LF) ?
                             cle_pkg::ST_IDLE : cle_pkg::ST_KILL_ISSUE;
            end
            cle_pkg::ST_READ_ISSUE:
            begin
                state_next = (buf_empty || (lim_reg == '0)) ?
                             cle_pkg::ST_IDLE : cle_pkg::ST_READ_DATA;
            end
            cle_pkg::ST_READ_DATA:
            begin
                state_next = rd_last ? cle_pkg::ST_IDLE : cle_pkg::ST_READ_ISSUE;
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, RAM control and results
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        fill_next  = fill_reg;
        kcnt_next  = kcnt_reg;
        rcnt_next  = rcnt_reg;
        valid_next = 1'b0;
        kind_next  = kind_reg;
        char_next  = char_reg;
        ecnt_next  = ecnt_reg;
        last_next  = last_reg;
        mem_we     = 1'b0;
        mem_waddr  = wp_reg;
        mem_wdata  = store_char;
        mem_re     = 1'b0;
        mem_raddr  = rp_reg;

        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kcnt_next = '0;
                    rcnt_next = '0;
                end
            end
            cle_pkg::ST_KEY:
            begin
                if (is_intr)
                begin
                    valid_next = 1'b1;
                    kind_next  = cle_pkg::KIND_INTR;
                    char_next  = '0;
                    ecnt_next  = '0;
                    last_next  = 1'b1;
                end
                else if (is_erase)
                begin
                    if (!buf_empty)
                    begin
                        wp_next    = cle_pkg::ptr_dec(wp_reg);
                        fill_next  = fill_reg - 1'b1;
                        valid_next = echo_reg;
                        kind_next  = cle_pkg::KIND_ECHO_ERASE;
                        char_next  = '0;
                        ecnt_next  = cle_pkg::ECNT_W'(1);
                        last_next  = 1'b1;
                    end
                end
                else if (!is_kill && !buf_full)
                begin
                    // store the character, CR folded to LF
                    mem_we     = 1'b1;
                    wp_next    = cle_pkg::ptr_inc(wp_reg);
                    fill_next  = fill_reg + 1'b1;
                    valid_next = echo_reg;
                    kind_next  = cle_pkg::KIND_ECHO_CHAR;
                    char_next  = store_char;
                    ecnt_next  = '0;
                    last_next  = 1'b1;
                end
            end
            cle_pkg::ST_KILL_ISSUE:
            begin
                if (buf_empty)
                begin
                    valid_next = echo_reg && (kcnt_reg != '0);
                    kind_next  = cle_pkg::KIND_ECHO_ERASE;
                    char_next  = '0;
                    ecnt_next  = kcnt_sat;
                    last_next  = 1'b1;
                end
                else
                begin
                    // fetch the newest character
                    mem_re    = 1'b1;
                    mem_raddr = cle_pkg::ptr_dec(wp_reg);
                end
            end
            cle_pkg::ST_KILL_CHECK:
            begin
                if (rdata_reg == cle_pkg::CH_LF)
                begin
                    valid_next = echo_reg && (kcnt_reg != '0);
                    kind_next  = cle_pkg::KIND_ECHO_ERASE;
                    char_next  = '0;
                    ecnt_next  = kcnt_sat;
                    last_next  = 1'b1;
                end
                else
                begin
                    wp_next   = cle_pkg::ptr_dec(wp_reg);
                    fill_next = fill_reg - 1'b1;
                    kcnt_next = kcnt_reg + 1'b1;
                end
            end
            cle_pkg::ST_READ_ISSUE:
            begin
                if (buf_empty || (lim_reg == '0))
                begin
                    if (rcnt_reg == '0)
                    begin
                        valid_next = 1'b1;
                        kind_next  = cle_pkg::KIND_READ_EMPTY;
                        char_next  = '0;
                        ecnt_next  = '0;
                        last_next  = 1'b1;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rp_reg;
                end
            end
            cle_pkg::ST_READ_DATA:
            begin
                rp_next    = cle_pkg::ptr_inc(rp_reg);
                fill_next  = fill_reg - 1'b1;
                rcnt_next  = rcnt_inc;
                valid_next = 1'b1;
                kind_next  = cle_pkg::KIND_READ_BYTE;
                char_next  = rdata_reg;
                ecnt_next  = '0;
                last_next  = rd_last;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    // character RAM with a registered read; write and read never hit the
    // same entry at the same edge since each item stores at most once and
    // finishes before the next one starts
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // latched item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_char_reg <= key_char;
            lim_reg      <= (read_limit > cle_pkg::LIM_W'(cle_pkg::MAX_READ)) ?
                            cle_pkg::LIM_W'(cle_pkg::MAX_READ) : read_limit;
        end
        kind_reg <= kind_next;
        char_reg <= char_next;
        ecnt_reg <= ecnt_next;
        last_reg <= last_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
            kcnt_reg  <= '0;
            rcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fill_reg  <= fill_next;
            kcnt_reg  <= kcnt_next;
            rcnt_reg  <= rcnt_next;
            valid_reg <= valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canon_reg <= 1'b1;
            echo_reg  <= 1'b1;
            sig_reg   <= 1'b1;
            intr_reg  <= cle_pkg::RST_INTR;
            erase_reg <= cle_pkg::RST_ERASE;
            kill_reg  <= cle_pkg::RST_KILL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cle_pkg::CFG_CANON:  canon_reg <= cfg_data[0];
                cle_pkg::CFG_ECHO:   echo_reg  <= cfg_data[0];
                cle_pkg::CFG_SIGNAL: sig_reg   <= cfg_data[0];
                cle_pkg::CFG_INTR:   intr_reg  <= cfg_data;
                cle_pkg::CFG_ERASE:  erase_reg <= cfg_data;
                cle_pkg::CFG_KILL:   kill_reg  <= cfg_data;
                default:             canon_reg <= canon_reg;
            endcase
        end
    end

    assign valid       = valid_reg;
    assign kind        = kind_reg;
    assign out_char    = char_reg;
    assign erase_count = ecnt_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/cle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker - port-level checks for the canonical line editor
// Watches the command and result ports and flags results that break the
// item framing or carry inconsistent fields.
// ----------------------------------------------------------------------------
module cle_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           valid,
    input logic [cle_pkg::KIND_W-1:0]     kind,
    input logic [cle_pkg::CHAR_W-1:0]     out_char,
    input logic [cle_pkg::ECNT_W-1:0]     erase_count,
    input logic                           last
);

    // a result only follows a cycle of work on an item
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result without a busy cycle before it");

    // the final result ends the item: nothing follows in the next cycle
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("result right after the final result of an item");

    // a read byte that is not the last keeps the editor busy
    a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> (kind == cle_pkg::KIND_READ_BYTE) && busy)
        else $error("non-final result outside a read");

    // erase echoes carry a count and no character
    a_erase_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (kind == cle_pkg::KIND_ECHO_ERASE)) |->
            (out_char == '0) && (erase_count != '0))
        else $error("erase echo with bad fields");

    // interrupt and empty-read results are single and bare
    a_bare_results: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ((kind == cle_pkg::KIND_INTR) || (kind == cle_pkg::KIND_READ_EMPTY))) |->
            last && (out_char == '0) && (erase_count == '0))
        else $error("interrupt or empty read with bad fields");

endmodule

bind canonical_line_editor cle_checker u_cle_checker (.*);

// ===== test/line_editor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_checker - scoreboard for the canonical line editor
// Follows register writes and accepted items, keeps its own copy of the
// line buffer and compares every result strobe with the oldest predicted
// console output.
// ----------------------------------------------------------------------------
module line_editor_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           req_type,
    input  logic [cle_pkg::CHAR_W-1:0]     key_char,
    input  logic [cle_pkg::LIM_W-1:0]      read_limit,
    input  logic                           valid,
    input  logic [cle_pkg::KIND_W-1:0]     kind,
    input  logic [cle_pkg::CHAR_W-1:0]     out_char,
    input  logic [cle_pkg::ECNT_W-1:0]     erase_count,
    input  logic                           last,
    input  logic                           cfg_we,
    input  logic [cle_pkg::CFG_W-1:0]      cfg_index,
    input  logic [cle_pkg::CHAR_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             results_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [cle_pkg::KIND_W-1:0] kind;
        logic [cle_pkg::CHAR_W-1:0] ch;
        logic [cle_pkg::ECNT_W-1:0] cnt;
        logic                       last;
    } console_out_t;

    console_out_t               console_out_q[$];
    logic [cle_pkg::CHAR_W-1:0] line_buf [cle_pkg::BUF_DEPTH];
    logic [cle_pkg::PTR_W-1:0]  wr_ptr;
    logic [cle_pkg::PTR_W-1:0]  rd_ptr;
    int                         fill;
    logic                       canon_on;
    logic                       echo_on;
    logic                       signal_on;
    logic [cle_pkg::CHAR_W-1:0] intr_code;
    logic [cle_pkg::CHAR_W-1:0] erase_code;
    logic [cle_pkg::CHAR_W-1:0] kill_code;
    int                         mismatches;
    int                         checked;

    task automatic queue_output(input logic [cle_pkg::KIND_W-1:0] k,
                                input logic [cle_pkg::CHAR_W-1:0] c,
                                input logic [cle_pkg::ECNT_W-1:0] n, input logic fin);
        console_out_t e;
        e.kind = k;
        e.ch   = c;
        e.cnt  = n;
        e.last = fin;
        console_out_q.push_back(e);
    endtask

    // Apply one accepted item to the buffer copy and queue the console output
    task automatic edit_line(input logic rt, input logic [cle_pkg::CHAR_W-1:0] ch,
                             input logic [cle_pkg::LIM_W-1:0] lim);
        logic [cle_pkg::CHAR_W-1:0] c;
        logic [cle_pkg::CHAR_W-1:0] b;
        logic [cle_pkg::PTR_W-1:0]  prev;
        int                         n;
        int                         cap;
        int                         taken;
        logic                       stop;
        c = ch;
        if (rt == cle_pkg::REQ_READ)
        begin
            cap   = (lim > cle_pkg::MAX_READ) ? cle_pkg::MAX_READ : int'(lim);
            taken = 0;
            stop  = 1'b0;
            while (!stop && taken < cap && fill != 0)
            begin
                b      = line_buf[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
                fill--;
                taken++;
                // a newline ends the read in canonical mode
                stop = (taken == cap) || (fill == 0) || (canon_on && b == cle_pkg::CH_LF);
                queue_output(cle_pkg::KIND_READ_BYTE, b, '0, stop);
            end
            if (taken == 0)
                queue_output(cle_pkg::KIND_READ_EMPTY, '0, '0, 1'b1);
        end
        else if (signal_on && c == intr_code)
        begin
            queue_output(cle_pkg::KIND_INTR, '0, '0, 1'b1);
        end
        else if (canon_on && (c == erase_code || c == cle_pkg::CH_DEL))
        begin
            // erase is checked ahead of kill, and is silent on an empty line
            if (fill != 0)
            begin
                wr_ptr = wr_ptr - 1'b1;
                fill--;
                if (echo_on)
                    queue_output(cle_pkg::KIND_ECHO_ERASE, '0, cle_pkg::ECNT_W'(1), 1'b1);
            end
        end
        else if (canon_on && c == kill_code)
        begin
            n    = 0;
            prev = wr_ptr - 1'b1;
            while (fill != 0 && line_buf[prev] != cle_pkg::CH_LF)
            begin
                wr_ptr = prev;
                prev   = wr_ptr - 1'b1;
                fill--;
                n++;
            end
            if (echo_on && n != 0)
                queue_output(cle_pkg::KIND_ECHO_ERASE, '0,
                             (n > cle_pkg::ECNT_MAX) ? cle_pkg::ECNT_MAX :
                             cle_pkg::ECNT_W'(n), 1'b1);
        end
        else if (fill < cle_pkg::BUF_DEPTH)
        begin
            if (c == cle_pkg::CH_CR)
                c = cle_pkg::CH_LF;
            line_buf[wr_ptr] = c;
            wr_ptr = wr_ptr + 1'b1;
            fill++;
            if (echo_on)
                queue_output(cle_pkg::KIND_ECHO_CHAR, c, '0, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        console_out_t want;
        if (!rst_n)
        begin
            console_out_q.delete();
            wr_ptr          = '0;
            rd_ptr          = '0;
            fill            = 0;
            canon_on        = 1'b1;
            echo_on         = 1'b1;
            signal_on       = 1'b1;
            intr_code       = cle_pkg::RST_INTR;
            erase_code      = cle_pkg::RST_ERASE;
            kill_code       = cle_pkg::RST_KILL;
            mismatches      = 0;
            checked         = 0;
            fail_count      <= 0;
            pending         <= 0;
            results_checked <= 0;
        end
        else
        begin
            // results first: a strobe at this edge belongs to an older item
            if (valid)
            begin
                if (console_out_q.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected result kind=%0d char=%02h count=%0d last=%0b",
                                 $time, kind, out_char, erase_count, last);
                    mismatches++;
                end
                else
                begin
                    want = console_out_q.pop_front();
                    checked++;
                    if (kind !== want.kind || out_char !== want.ch ||
                        erase_count !== want.cnt || last !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: result mismatch, expected kind=%0d char=%02h ",
                                      "count=%0d last=%0b, got kind=%0d char=%02h ",
                                      "count=%0d last=%0b"},
                                     $time, want.kind, want.ch, want.cnt, want.last,
                                     kind, out_char, erase_count, last);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    cle_pkg::CFG_CANON:  canon_on   = cfg_data[0];
                    cle_pkg::CFG_ECHO:   echo_on    = cfg_data[0];
                    cle_pkg::CFG_SIGNAL: signal_on  = cfg_data[0];
                    cle_pkg::CFG_INTR:   intr_code  = cfg_data;
                    cle_pkg::CFG_ERASE:  erase_code = cfg_data;
                    cle_pkg::CFG_KILL:   kill_code  = cfg_data;
                    default:             ;
                endcase
            end
            if (start && !busy)
                edit_line(req_type, key_char, read_limit);
            fail_count      <= mismatches;
            pending         <= console_out_q.size();
            results_checked <= checked;
        end
    end

endmodule

// ===== test/tb_canonical_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_line_editor - testbench for the canonical line editor
// Drives directed key and read items and random typing sessions under
// several register settings, with random gaps between items; a separate
// checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_canonical_line_editor;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int QUIET_CYCLES    = 16;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 40;

    localparam logic                      REQ_KEY      = ~cle_pkg::REQ_READ;
    localparam logic [cle_pkg::CFG_W-1:0] CFG_SPARE_LO = cle_pkg::CFG_KILL + 3'd1;
    localparam logic [cle_pkg::CFG_W-1:0] CFG_SPARE_HI = '1;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         req_type;
    logic [cle_pkg::CHAR_W-1:0]   key_char;
    logic [cle_pkg::LIM_W-1:0]    read_limit;
    logic                         valid;
    logic [cle_pkg::KIND_W-1:0]   kind;
    logic [cle_pkg::CHAR_W-1:0]   out_char;
    logic [cle_pkg::ECNT_W-1:0]   erase_count;
    logic                         last;
    logic                         cfg_we;
    logic [cle_pkg::CFG_W-1:0]    cfg_index;
    logic [cle_pkg::CHAR_W-1:0]   cfg_data;

    int                           fail_count;
    int                           pending;
    int                           results_checked;
    int                           cycle_count = 0;
    int                           key_items;
    int                           read_items;
    int                           settings;
    logic                         no_gaps;

    // current register values, used only to shape the stimulus
    logic                         m_canon;
    logic                         m_echo;
    logic                         m_signal;
    logic [cle_pkg::CHAR_W-1:0]   m_intr;
    logic [cle_pkg::CHAR_W-1:0]   m_erase;
    logic [cle_pkg::CHAR_W-1:0]   m_kill;

    canonical_line_editor u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key_char    (key_char),
        .read_limit  (read_limit),
        .valid       (valid),
        .kind        (kind),
        .out_char    (out_char),
        .erase_count (erase_count),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    line_editor_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .key_char        (key_char),
        .read_limit      (read_limit),
        .valid           (valid),
        .kind            (kind),
        .out_char        (out_char),
        .erase_count     (erase_count),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit of %0d reached", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [cle_pkg::CFG_W-1:0] idx,
                             input logic [cle_pkg::CHAR_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic canon, input logic echo, input logic sig,
                            input logic [cle_pkg::CHAR_W-1:0] intr,
                            input logic [cle_pkg::CHAR_W-1:0] erase,
                            input logic [cle_pkg::CHAR_W-1:0] kill);
        write_reg(cle_pkg::CFG_CANON, cle_pkg::CHAR_W'(canon));
        write_reg(cle_pkg::CFG_ECHO, cle_pkg::CHAR_W'(echo));
        write_reg(cle_pkg::CFG_SIGNAL, cle_pkg::CHAR_W'(sig));
        write_reg(cle_pkg::CFG_INTR, intr);
        write_reg(cle_pkg::CFG_ERASE, erase);
        write_reg(cle_pkg::CFG_KILL, kill);
        m_canon  = canon;
        m_echo   = echo;
        m_signal = sig;
        m_intr   = intr;
        m_erase  = erase;
        m_kill   = kill;
        settings++;
    endtask

    // Drop start, wait for every expected result and for the block to go idle
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_item(input logic rt, input logic [cle_pkg::CHAR_W-1:0] ch,
                             input logic [cle_pkg::LIM_W-1:0] lim);
        int r;
        int gap;
        if ($urandom_range(0, 19) == 0)
            no_gaps = ~no_gaps;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        req_type   <= rt;
        key_char   <= ch;
        read_limit <= lim;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (rt == cle_pkg::REQ_READ)
            read_items++;
        else
            key_items++;
    endtask

    task automatic send_key(input logic [cle_pkg::CHAR_W-1:0] ch);
        send_item(REQ_KEY, ch, cle_pkg::LIM_W'($urandom_range(0, (1 << cle_pkg::LIM_W) - 1)));
    endtask

    task automatic send_read(input logic [cle_pkg::LIM_W-1:0] lim);
        send_item(cle_pkg::REQ_READ, cle_pkg::CHAR_W'($urandom_range(0, 255)), lim);
    endtask

    task automatic random_item();
        int                         r;
        logic [cle_pkg::CHAR_W-1:0] ch;
        logic [cle_pkg::LIM_W-1:0]  lim;
        r = $urandom_range(0, 99);
        if (r >= 78)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                lim = '0;
            else if (r == 1)
                lim = cle_pkg::LIM_W'($urandom_range(cle_pkg::MAX_READ + 1,
                                                     (1 << cle_pkg::LIM_W) - 1));
            else
                lim = cle_pkg::LIM_W'($urandom_range(1, cle_pkg::MAX_READ));
            send_read(lim);
        end
        else
        begin
            if (r < 50)
                ch = cle_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
            else if (r < 58)
                ch = cle_pkg::CHAR_W'($urandom_range(0, 255));
            else if (r < 66)
                ch = r[0] ? cle_pkg::CH_LF : cle_pkg::CH_CR;
            else if (r < 71)
                ch = m_erase;
            else if (r < 74)
                ch = cle_pkg::CH_DEL;
            else if (r < 77)
                ch = m_kill;
            else
                ch = m_intr;
            send_key(ch);
        end
    endtask

    initial
    begin : stimulus
        int                         ph;
        int                         i;
        logic [cle_pkg::CHAR_W-1:0] pick;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = 1'b0;
        key_char   = '0;
        read_limit = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_gaps    = 1'b0;
        key_items  = 0;
        read_items = 0;
        settings   = 1;
        m_canon    = 1'b1;
        m_echo     = 1'b1;
        m_signal   = 1'b1;
        m_intr     = cle_pkg::RST_INTR;
        m_erase    = cle_pkg::RST_ERASE;
        m_kill     = cle_pkg::RST_KILL;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty-buffer cases, editing, reads
        send_read(cle_pkg::LIM_W'(5));
        send_key(cle_pkg::RST_ERASE);
        send_key(cle_pkg::CH_DEL);
        send_key(cle_pkg::RST_KILL);
        send_key(cle_pkg::RST_INTR);
        send_key(8'h61);
        send_key(8'h00);
        send_key(8'hFF);
        send_key(cle_pkg::CH_CR);
        send_key(8'h62);
        send_key(8'h63);
        send_key(cle_pkg::RST_ERASE);
        send_key(cle_pkg::CH_DEL);
        send_key(8'h78);
        send_key(8'h79);
        send_key(cle_pkg::RST_KILL);
        send_key(cle_pkg::RST_KILL);
        send_read('0);
        send_read('1);
        send_key(8'h70);
        send_key(8'h71);
        send_key(8'h72);
        send_read(cle_pkg::LIM_W'(2));
        send_read(cle_pkg::LIM_W'(cle_pkg::MAX_READ));

        // erase and kill on the same code; writes past the last register
        wait_quiet();
        set_mode(1'b1, 1'b1, 1'b1, cle_pkg::RST_INTR, cle_pkg::RST_KILL, cle_pkg::RST_KILL);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        send_key(8'h6D);
        send_key(cle_pkg::RST_KILL);
        send_key(8'h6E);
        send_read('1);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_quiet();
            case (ph)
                0: set_mode(1'b1, 1'b1, 1'b1, cle_pkg::RST_INTR, cle_pkg::RST_ERASE,
                            cle_pkg::RST_KILL);
                1: set_mode(1'b0, 1'b1, 1'b1, 8'h00, 8'hFF, 8'h00);
                2: set_mode(1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 8'hFF);
                3: set_mode(1'b1, 1'b1, 1'b0, cle_pkg::CHAR_W'($urandom_range(0, 255)),
                            8'hFF, 8'h00);
                4: set_mode(1'b0, 1'b0, 1'b1, 8'hFF, cle_pkg::CHAR_W'($urandom_range(0, 255)),
                            cle_pkg::CHAR_W'($urandom_range(0, 255)));
                default:
                begin
                    pick = cle_pkg::CHAR_W'($urandom_range(0, 255));
                    set_mode(1'b1, 1'b1, 1'b1, cle_pkg::CHAR_W'($urandom_range(0, 255)),
                             pick, pick);
                end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                random_item();
                // hold off now and then until the output has drained
                if ($urandom_range(0, 29) == 0)
                    wait_quiet();
            end
        end

        wait_quiet();
        $display("Drove %0d key items and %0d read items over %0d register settings,",
                 key_items, read_items, settings);
        $display("with editing, interrupts and reads; %0d results checked, %0d mismatches.",
                 results_checked, fail_count);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== canonical_line_editor.f =====
hw/rtl/cle_pkg.sv
hw/rtl/canonical_line_editor.sv
hw/rtl/cle_checker.sv
test/line_editor_checker.sv
test/tb_canonical_line_editor.sv
